// File: rtl/core/jep_pkg.sv
`default_nettype none

package jep_pkg;

  localparam int MAX_PEOPLE_DEF = 64;
  localparam int PERSON_W       = 7;
  localparam int RING_W         = 7;
  localparam int START_W        = 7;
  localparam int STEP_W         = 10;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_SIZE  = 2'd0,
    REG_START_POS  = 2'd1,
    REG_STEP_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_FETCH,
    ST_WALK,
    ST_NONE
  } state_t;

  typedef struct packed {
    logic                load;
    logic [PERSON_W-1:0] person;
    logic                last;
    logic                none_left;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/jep_link_ram.sv
`default_nettype none

module jep_link_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/jep_ctrl.sv
`default_nettype none

module jep_ctrl #(
  parameter int MAX_PEOPLE = jep_pkg::MAX_PEOPLE_DEF,
  parameter int IW         = $clog2(MAX_PEOPLE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  input  logic [jep_pkg::RING_W-1:0]  ring_size,
  input  logic [jep_pkg::START_W-1:0] start_pos,
  input  logic [jep_pkg::STEP_W-1:0]  step_count,
  input  logic                        out_free,
  output jep_pkg::result_t            res,
  output logic                        ram_we,
  output logic [IW-1:0]               ram_waddr,
  output logic [IW-1:0]               ram_wdata,
  output logic [IW-1:0]               ram_raddr,
  input  logic [IW-1:0]               ram_rdata
);

  import jep_pkg::*;

  localparam int NW = $clog2(MAX_PEOPLE + 1);
  localparam int SW = (NW > RING_W) ? NW : RING_W;
  localparam int XW = (IW + 1 > PERSON_W) ? IW + 1 : PERSON_W;

  state_t state, state_next;

  logic [IW-1:0]     cur, prev;
  logic [NW-1:0]     remaining;
  logic [NW-1:0]     n_reg;
  logic [NW-1:0]     bi;
  logic [SW-1:0]     red;
  logic [STEP_W-1:0] cnt;

  logic [SW-1:0] ring_ext, max_ext, n_ext;
  logic [NW-1:0] n_eff, bi_inc;
  logic          build_done, red_lt_n, emit, walk_more;
  logic [IW-1:0] r_low, nm1, s_idx, p_idx;
  logic [XW-1:0] psum;

  // ring size clamped to 1..MAX_PEOPLE
  assign ring_ext = SW'(ring_size);
  assign max_ext  = SW'(MAX_PEOPLE);
  always_comb begin
    if (ring_size == '0) begin
      n_eff = NW'(1);
    end else if (ring_ext > max_ext) begin
      n_eff = max_ext[NW-1:0];
    end else begin
      n_eff = ring_ext[NW-1:0];
    end
  end

  assign n_ext      = SW'(n_reg);
  assign bi_inc     = bi + NW'(1);
  assign build_done = (bi == n_reg);
  assign red_lt_n   = (red < n_ext);

  // start index: (start_pos mod n) - 1, wrapping to n-1; predecessor one back
  assign r_low = red[IW-1:0];
  assign nm1   = IW'(n_reg - NW'(1));
  assign s_idx = (r_low == '0) ? nm1 : r_low - IW'(1);
  assign p_idx = (s_idx == '0) ? nm1 : s_idx - IW'(1);

  assign walk_more = (cnt != '0);
  assign emit      = (state == ST_WALK) && !walk_more && out_free;
  assign psum      = XW'(cur) + XW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            state_next = ST_BUILD;
          end else if (remaining == '0) begin
            state_next = ST_NONE;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_BUILD: begin
        if (build_done && red_lt_n) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_WALK;
      ST_WALK: begin
        if (!walk_more && out_free) state_next = ST_IDLE;
      end
      ST_NONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = (state == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = prev;
    ram_wdata     = ram_rdata;
    ram_raddr     = cur;
    res.load      = 1'b0;
    res.person    = '0;
    res.last      = 1'b0;
    res.none_left = 1'b0;
    case (state)
      ST_BUILD: begin
        ram_we    = !build_done;
        ram_waddr = bi[IW-1:0];
        ram_wdata = (bi_inc == n_reg) ? '0 : bi_inc[IW-1:0];
      end
      ST_WALK: begin
        // chase the link just read while steps remain
        if (walk_more) ram_raddr = ram_rdata;
        ram_we     = emit;
        res.load   = emit;
        res.person = psum[PERSON_W-1:0];
        res.last   = (remaining == NW'(1));
      end
      ST_NONE: begin
        res.load      = out_free;
        res.none_left = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      prev      <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_BUILD: begin
          if (build_done && red_lt_n) begin
            cur       <= s_idx;
            prev      <= p_idx;
            remaining <= n_reg;
          end
        end
        ST_WALK: begin
          if (walk_more) begin
            prev <= cur;
            cur  <= ram_rdata;
          end else if (out_free) begin
            cur       <= ram_rdata;
            remaining <= remaining - NW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cnt <= (step_count == '0) ? '0 : step_count - STEP_W'(1);
          if (restart) begin
            n_reg <= n_eff;
            red   <= SW'(start_pos);
            bi    <= '0;
          end
        end
      end
      ST_BUILD: begin
        if (!build_done) bi <= bi_inc;
        // start_pos mod n by repeated subtraction, alongside the link sweep
        if (!red_lt_n) red <= red - n_ext;
      end
      ST_WALK: begin
        if (walk_more) cnt <= cnt - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/josephus_elimination_order.sv
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_ready    restart
// out       out_valid / out_ready  person, last, none_left
// cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// One request at a time; in_ready is low while a request is in work.
// Normal request: accept cycle, one link fetch, step_count - 1 successor link reads,
//   then the emit/unlink cycle; a step_count of 0 acts as 1.
// Restart adds a link sweep over the n entries of the clamped ring, one entry a cycle,
//   with the start reduction alongside.
// Result sits in an output register; the block stalls in its last cycle
//   only while that register is full and out_ready is low. Reset is synchronous; link RAM is not cleared.

module josephus_elimination_order #(
  parameter int MAX_PEOPLE = jep_pkg::MAX_PEOPLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jep_pkg::PERSON_W-1:0]   person,
  output logic                           last,
  output logic                           none_left,
  input  logic                           cfg_we,
  input  logic [jep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jep_pkg::CFG_DATA_W-1:0] cfg_data
);

  import jep_pkg::*;

  localparam int IW = $clog2(MAX_PEOPLE);

  logic [RING_W-1:0]  ring_size;
  logic [START_W-1:0] start_pos;
  logic [STEP_W-1:0]  step_count;

  result_t       res;
  logic          out_free;
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= RING_W'(1);
      start_pos  <= START_W'(1);
      step_count <= STEP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_SIZE:  ring_size  <= cfg_data[RING_W-1:0];
        REG_START_POS:  start_pos  <= cfg_data[START_W-1:0];
        REG_STEP_COUNT: step_count <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      person    <= res.person;
      last      <= res.last;
      none_left <= res.none_left;
    end
  end

  jep_ctrl #(
    .MAX_PEOPLE (MAX_PEOPLE),
    .IW         (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .ring_size  (ring_size),
    .start_pos  (start_pos),
    .step_count (step_count),
    .out_free   (out_free),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  jep_link_ram #(
    .DEPTH (MAX_PEOPLE),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/jep_checker.sv
`default_nettype none

module jep_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [jep_pkg::PERSON_W-1:0]   person,
  input logic                           last,
  input logic                           none_left
);

  // result held while the consumer stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(person) && $stable(last)
      && $stable(none_left))
    else $error("stalled result changed");

  // an accepted request takes the block out of idle, so in_ready goes low
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after request");

  a_none_no_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(last && none_left))
    else $error("last and none_left together");

  a_none_person_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_left |-> person == '0)
    else $error("none_left with nonzero person");

endmodule

bind josephus_elimination_order jep_checker u_jep_checker (.*);

`default_nettype wire
